>>> rtl/bxavg_pkg.sv
// bxavg_pkg: shared constants, controller state type and the command and
// status groups between controller and datapath of the box average downscaler.
// No dependencies.
package bxavg_pkg;

    // default parameter values
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_FACTOR_DEF = 8;

    // fixed field widths
    localparam int PIX_W        = 8;
    localparam int FRAME_REG_W  = 11;
    localparam int FACTOR_REG_W = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 11;

    // divider produces one quotient bit per step
    localparam int DIV_STEP_W = $clog2(PIX_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COUNT        = CFG_IDX_W'(4);

    // reset values of the registers
    localparam logic [FRAME_REG_W-1:0]  FRAME_WIDTH_RST  = FRAME_REG_W'(160);
    localparam logic [FRAME_REG_W-1:0]  FRAME_HEIGHT_RST = FRAME_REG_W'(210);
    localparam logic [FACTOR_REG_W-1:0] BLOCK_WIDTH_RST  = FACTOR_REG_W'(2);
    localparam logic [FACTOR_REG_W-1:0] BLOCK_HEIGHT_RST = FACTOR_REG_W'(2);

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_LOAD
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;    // capture pixel, read line store
        logic update;    // write line store, advance counters
        logic div_step;  // one quotient bit
        logic out_load;  // move quotient into output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;      // current pixel closes a block
        logic div_last;  // last quotient bit this step
        logic out_free;  // output register can take a word
    } dp_status_t;

endpackage

>>> rtl/bxavg_if.sv
// bxavg_if: valid/ready channel interfaces for pixels in, averages out and
// register writes. Depends on bxavg_pkg.
interface bxavg_pixel_if;
    import bxavg_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface bxavg_avg_if;
    import bxavg_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

interface bxavg_cfg_if;
    import bxavg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/bxavg_cfg.sv
// bxavg_cfg: configuration registers with range clamping and frame restart.
// Depends on bxavg_pkg and bxavg_if.
module bxavg_cfg #(
    parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bxavg_cfg_if.sink                            cfg,
    output logic [$clog2(MAX_WIDTH+1)-1:0]       frame_w,
    output logic [$clog2(MAX_WIDTH+1)-1:0]       frame_h,
    output logic [$clog2(MAX_FACTOR+1)-1:0]      block_w,
    output logic [$clog2(MAX_FACTOR+1)-1:0]      block_h,
    output logic                                 restart
);
    import bxavg_pkg::*;

    localparam int FDW = $clog2(MAX_WIDTH+1);
    localparam int FFW = $clog2(MAX_FACTOR+1);

    logic [FRAME_REG_W-1:0]  frame_width_reg;
    logic [FRAME_REG_W-1:0]  frame_height_reg;
    logic [FACTOR_REG_W-1:0] block_width_reg;
    logic [FACTOR_REG_W-1:0] block_height_reg;
    logic                    write;

    assign cfg.ready = 1'b1;
    assign write     = cfg.valid;
    assign restart   = write && (cfg.index < REG_COUNT);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            block_width_reg  <= BLOCK_WIDTH_RST;
            block_height_reg <= BLOCK_HEIGHT_RST;
        end
        else if (write)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                REG_BLOCK_WIDTH:  block_width_reg  <= cfg.data[FACTOR_REG_W-1:0];
                REG_BLOCK_HEIGHT: block_height_reg <= cfg.data[FACTOR_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp frame size to 1..MAX_WIDTH
    always_comb
    begin
        if (frame_width_reg == '0)
            frame_w = FDW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            frame_w = FDW'(MAX_WIDTH);
        else
            frame_w = FDW'(frame_width_reg);

        if (frame_height_reg == '0)
            frame_h = FDW'(1);
        else if (32'(frame_height_reg) > MAX_WIDTH)
            frame_h = FDW'(MAX_WIDTH);
        else
            frame_h = FDW'(frame_height_reg);
    end

    // clamp block factors to 1..MAX_FACTOR
    always_comb
    begin
        if (block_width_reg == '0)
            block_w = FFW'(1);
        else if (32'(block_width_reg) > MAX_FACTOR)
            block_w = FFW'(MAX_FACTOR);
        else
            block_w = FFW'(block_width_reg);

        if (block_height_reg == '0)
            block_h = FFW'(1);
        else if (32'(block_height_reg) > MAX_FACTOR)
            block_h = FFW'(MAX_FACTOR);
        else
            block_h = FFW'(block_height_reg);
    end

endmodule

>>> rtl/bxavg_ctrl.sv
// bxavg_ctrl: sequencer for one pixel at a time: update, divide, load output.
// Depends on bxavg_pkg.
module bxavg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bxavg_pkg::dp_status_t   status,
    output bxavg_pkg::dp_cmd_t      cmd
);
    import bxavg_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = status.emit ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.out_load = (state_reg == ST_LOAD) && status.out_free;
    end

endmodule

>>> rtl/bxavg_dp.sv
// bxavg_dp: position counters, line store of block sums, bit-serial divider
// and output register. Depends on bxavg_pkg.
module bxavg_dp #(
    parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       frame_w,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       frame_h,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]      block_w,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]      block_h,
    input  logic                                 restart,
    input  logic [bxavg_pkg::PIX_W-1:0]          pixel_in,
    input  bxavg_pkg::dp_cmd_t                   cmd,
    output bxavg_pkg::dp_status_t                status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bxavg_pkg::PIX_W-1:0]          pixel_out,
    output logic                                 row_end,
    output logic                                 frame_end
);
    import bxavg_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int FDW   = $clog2(MAX_WIDTH+1);
    localparam int FFW   = $clog2(MAX_FACTOR+1);
    localparam int SCW   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int AW    = $clog2(MAX_FACTOR*MAX_FACTOR+1);
    localparam int SUM_W = PIX_W + 2*SCW;
    localparam int EW    = FDW + 2;
    localparam int CMPW  = FFW + 1;
    localparam int DW    = SUM_W + PIX_W;

    // line store
    logic [SUM_W-1:0] sums_mem [MAX_WIDTH];
    logic [SUM_W-1:0] rd_data_reg;

    // position state
    logic [CW-1:0]  col_pos_reg,  col_pos_next;
    logic [CW-1:0]  row_pos_reg,  row_pos_next;
    logic [SCW-1:0] sub_col_reg,  sub_col_next;
    logic [SCW-1:0] sub_row_reg,  sub_row_next;
    logic [CW-1:0]  out_col_reg,  out_col_next;
    logic [CW-1:0]  col_base_reg, col_base_next;
    logic [CW-1:0]  row_base_reg, row_base_next;

    logic [PIX_W-1:0] pix_reg;

    // divider and output state
    logic [SUM_W-1:0]      rem_reg,  rem_next;
    logic [PIX_W-1:0]      quo_reg,  quo_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  last_col_reg, last_row_reg;
    logic                  out_valid_reg;
    logic [PIX_W-1:0]      pixel_out_reg;
    logic                  row_end_reg, frame_end_reg;

    logic [AW-1:0]    area;
    logic             in_block, first_px, last_px, emit;
    logic             last_col, last_row;
    logic [SUM_W-1:0] acc;
    logic [DW-1:0]    div_shifted, div_rem_ext;

    // block geometry of the current pixel
    always_comb
    begin
        in_block = (EW'(col_base_reg) + EW'(block_w) <= EW'(frame_w))
                && (EW'(row_base_reg) + EW'(block_h) <= EW'(frame_h));
        first_px = (sub_col_reg == '0) && (sub_row_reg == '0);
        last_px  = (CMPW'(sub_col_reg) + CMPW'(1) == CMPW'(block_w))
                && (CMPW'(sub_row_reg) + CMPW'(1) == CMPW'(block_h));
        emit     = in_block && last_px;
        last_col = EW'(col_base_reg) + EW'(block_w) + EW'(block_w) > EW'(frame_w);
        last_row = EW'(row_base_reg) + EW'(block_h) + EW'(block_h) > EW'(frame_h);
        acc      = first_px ? SUM_W'(pix_reg) : rd_data_reg + SUM_W'(pix_reg);
        area     = AW'(block_w) * AW'(block_h);
    end

    // line store read on accept, write on update inside a whole block
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_data_reg <= sums_mem[out_col_reg];
            pix_reg     <= pixel_in;
        end
        if (cmd.update && in_block)
            sums_mem[out_col_reg] <= acc;
    end

    // raster position advance
    always_comb
    begin
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        sub_col_next  = sub_col_reg;
        sub_row_next  = sub_row_reg;
        out_col_next  = out_col_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        if (restart)
        begin
            col_pos_next  = '0;
            row_pos_next  = '0;
            sub_col_next  = '0;
            sub_row_next  = '0;
            out_col_next  = '0;
            col_base_next = '0;
            row_base_next = '0;
        end
        else if (cmd.update)
        begin
            if (EW'(col_pos_reg) + EW'(1) >= EW'(frame_w))
            begin
                col_pos_next  = '0;
                sub_col_next  = '0;
                out_col_next  = '0;
                col_base_next = '0;
                if (EW'(row_pos_reg) + EW'(1) >= EW'(frame_h))
                begin
                    row_pos_next  = '0;
                    sub_row_next  = '0;
                    row_base_next = '0;
                end
                else
                begin
                    row_pos_next = row_pos_reg + CW'(1);
                    if (CMPW'(sub_row_reg) + CMPW'(1) >= CMPW'(block_h))
                    begin
                        sub_row_next  = '0;
                        row_base_next = row_base_reg + CW'(block_h);
                    end
                    else
                        sub_row_next = sub_row_reg + SCW'(1);
                end
            end
            else
            begin
                col_pos_next = col_pos_reg + CW'(1);
                if (CMPW'(sub_col_reg) + CMPW'(1) >= CMPW'(block_w))
                begin
                    sub_col_next  = '0;
                    out_col_next  = out_col_reg + CW'(1);
                    col_base_next = col_base_reg + CW'(block_w);
                end
                else
                    sub_col_next = sub_col_reg + SCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            sub_col_reg  <= '0;
            sub_row_reg  <= '0;
            out_col_reg  <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            sub_col_reg  <= sub_col_next;
            sub_row_reg  <= sub_row_next;
            out_col_reg  <= out_col_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
        end
    end

    // restoring divider, one quotient bit per step from the top
    always_comb
    begin
        div_shifted = DW'(area) << step_reg;
        div_rem_ext = DW'(rem_reg);
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        if (cmd.update)
        begin
            rem_next  = acc;
            quo_next  = '0;
            step_next = DIV_STEP_W'(PIX_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (div_rem_ext >= div_shifted)
            begin
                rem_next           = SUM_W'(div_rem_ext - div_shifted);
                quo_next[step_reg] = 1'b1;
            end
            step_next = step_reg - DIV_STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        if (cmd.update)
        begin
            last_col_reg <= last_col;
            last_row_reg <= last_row;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_out_reg <= quo_reg;
            row_end_reg   <= last_col_reg;
            frame_end_reg <= last_col_reg && last_row_reg;
        end
    end

    // status and ports
    always_comb
    begin
        status.emit     = emit;
        status.div_last = (step_reg == '0);
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> rtl/box_average_downscaler.sv
// box_average_downscaler: top level, joins registers, controller and datapath.
// Depends on bxavg_pkg, bxavg_if, bxavg_cfg, bxavg_ctrl and bxavg_dp.
//
// Usage:
//   pixels   - 8-bit grayscale pixels in raster order, valid/ready
//   averages - one word per whole block: floor of block sum over block area,
//              with row_end on the last block of an output row and frame_end
//              on the last block of the frame
//   cfg      - register writes (0 frame_width, 1 frame_height, 2 block_width,
//              3 block_height); always ready, a write to a listed register
//              restarts the frame at its first pixel
// Timing:
//   a pixel that does not close a block passes through accept and line store
//   update; a pixel that closes a block passes through accept, update, the 8
//   steps of the bit-serial divider and output load, held until output is free
//   the average is valid in the cycle after the load step
// Reset:
//   registers return to 160 x 210 with 2 x 2 blocks, counters to frame start;
//   the line store is not cleared; a block's first pixel overwrites its entry
// Stall:
//   one output register; the next pixel is taken while a word waits, and the
//   divider holds its result until the output register is free
module box_average_downscaler #(
    parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bxavg_pixel_if.sink   pixels,
    bxavg_avg_if.source   averages,
    bxavg_cfg_if.sink     cfg
);
    import bxavg_pkg::*;

    localparam int FDW = $clog2(MAX_WIDTH+1);
    localparam int FFW = $clog2(MAX_FACTOR+1);

    logic [FDW-1:0] frame_w;
    logic [FDW-1:0] frame_h;
    logic [FFW-1:0] block_w;
    logic [FFW-1:0] block_h;
    logic           restart;
    dp_cmd_t        cmd;
    dp_status_t     status;

    // configuration registers
    bxavg_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .frame_w (frame_w),
        .frame_h (frame_h),
        .block_w (block_w),
        .block_h (block_h),
        .restart (restart)
    );

    // sequencer
    bxavg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    bxavg_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .block_w   (block_w),
        .block_h   (block_h),
        .restart   (restart),
        .pixel_in  (pixels.pixel_in),
        .cmd       (cmd),
        .status    (status),
        .out_valid (averages.valid),
        .out_ready (averages.ready),
        .pixel_out (averages.pixel_out),
        .row_end   (averages.row_end),
        .frame_end (averages.frame_end)
    );

endmodule

>>> sim/box_average_downscaler_tb.sv
// box_average_downscaler_tb: checks block averages, row and frame marks against
// a cycle-free model of the downscaler, over directed, extreme and random frames.
// Depends on bxavg_pkg, bxavg_if and the box_average_downscaler RTL.
`timescale 1ns / 1ps

module box_average_downscaler_tb;
    import bxavg_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;
    localparam int MAX_F = MAX_FACTOR_DEF;
    // cycles after the last average before the block is surely idle
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PIXELS = 700;
    // pixels sent into each saturated frame
    localparam int WIDE_PIXELS = 256;
    localparam int TALL_PIXELS = 128;

    // one expected average word
    typedef struct packed {
        logic [PIX_W-1:0] avg;
        logic             row_end;
        logic             frame_end;
    } avg_word_t;

    logic clk;
    logic rst_n;

    bxavg_pixel_if pix_if();
    bxavg_avg_if   avg_if();
    bxavg_cfg_if   cfg_if();

    box_average_downscaler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pix_if),
        .averages (avg_if),
        .cfg      (cfg_if)
    );

    // model registers and counters
    logic [FRAME_REG_W-1:0]  frame_width_reg;
    logic [FRAME_REG_W-1:0]  frame_height_reg;
    logic [FACTOR_REG_W-1:0] block_width_reg;
    logic [FACTOR_REG_W-1:0] block_height_reg;
    int line_sums [0:MAX_W-1];
    int col_pos, row_pos, sub_col, sub_row, out_col, out_row;

    avg_word_t pending_avgs[$];
    avg_word_t head_avg;

    int  mismatch_count;
    int  pixel_count;
    int  avg_count;
    int  reg_write_count;
    bit  sender_idle_en;
    bit  receiver_stall_en;

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hard limit on run time
    initial
    begin
        #5_000_000;
        $display("timeout: %0d averages still expected", pending_avgs.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int clamp_to(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void restart_position();
        col_pos = 0;
        row_pos = 0;
        sub_col = 0;
        sub_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic int frame_pixels();
        return clamp_to(frame_width_reg, MAX_W) * clamp_to(frame_height_reg, MAX_W);
    endfunction

    // model of one pixel: block sum update, optional average, position advance
    function automatic void predict_average(input logic [PIX_W-1:0] pix);
        int fw, fh, bw, bh, acc;
        avg_word_t w;
        fw = clamp_to(frame_width_reg, MAX_W);
        fh = clamp_to(frame_height_reg, MAX_W);
        bw = clamp_to(block_width_reg, MAX_F);
        bh = clamp_to(block_height_reg, MAX_F);
        if (out_col < fw / bw && out_row < fh / bh)
        begin
            // first pixel of a block overwrites the stored sum
            if (sub_col == 0 && sub_row == 0)
                acc = pix;
            else
                acc = line_sums[out_col] + pix;
            line_sums[out_col] = acc;
            if (sub_col + 1 == bw && sub_row + 1 == bh)
            begin
                w.avg       = PIX_W'(acc / (bw * bh));
                w.row_end   = (out_col + 1 == fw / bw);
                w.frame_end = w.row_end && (out_row + 1 == fh / bh);
                pending_avgs = {pending_avgs, w};
            end
        end
        if (col_pos + 1 >= fw)
        begin
            col_pos = 0;
            sub_col = 0;
            out_col = 0;
            if (row_pos + 1 >= fh)
                restart_position();
            else
            begin
                row_pos++;
                sub_row++;
                if (sub_row >= bh)
                begin
                    sub_row = 0;
                    out_row++;
                end
            end
        end
        else
        begin
            col_pos++;
            sub_col++;
            if (sub_col >= bw)
            begin
                sub_col = 0;
                out_col++;
            end
        end
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // sender: one pixel word, at times with a random gap ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (sender_idle_en && $urandom_range(99) < 16)
        begin
            @(negedge clk);
            pix_if.valid    <= 1'b0;
            pix_if.pixel_in <= PIX_W'($urandom);
            repeat ($urandom_range(2)) @(negedge clk);
        end
        @(negedge clk);
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= pix;
        do
            @(posedge clk);
        while (!pix_if.ready);
        pixel_count++;
        predict_average(pix);
    endtask

    task automatic stop_pixels();
        @(negedge clk);
        pix_if.valid <= 1'b0;
    endtask

    task automatic wait_for_averages();
        while (pending_avgs.size() != 0)
            @(posedge clk);
    endtask

    // register write, only once the block has drained
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        stop_pixels();
        wait_for_averages();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        reg_write_count++;
        case (idx)
            REG_FRAME_WIDTH:  frame_width_reg  = data;
            REG_FRAME_HEIGHT: frame_height_reg = data;
            REG_BLOCK_WIDTH:  block_width_reg  = data[FACTOR_REG_W-1:0];
            REG_BLOCK_HEIGHT: block_height_reg = data[FACTOR_REG_W-1:0];
            default: ;
        endcase
        if (idx < REG_COUNT)
            restart_position();
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_IDX_W'($urandom);
        cfg_if.data  <= CFG_DATA_W'($urandom);
    endtask

    // receiver: random stalls
    always @(negedge clk)
        avg_if.ready <= !receiver_stall_en || ($urandom_range(99) >= 16);

    // checker: each average word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && avg_if.valid && avg_if.ready)
        begin
            avg_count++;
            if (pending_avgs.size() == 0)
                report_mismatch($sformatf("unexpected average %0h row_end %0b frame_end %0b",
                                          avg_if.pixel_out, avg_if.row_end, avg_if.frame_end));
            else
            begin
                head_avg = pending_avgs.pop_front();
                if (avg_if.pixel_out !== head_avg.avg || avg_if.row_end !== head_avg.row_end
                    || avg_if.frame_end !== head_avg.frame_end)
                    report_mismatch($sformatf(
                        "word %0d: got %0h/%0b/%0b, want %0h/%0b/%0b (avg/row_end/frame_end)",
                        avg_count, avg_if.pixel_out, avg_if.row_end, avg_if.frame_end,
                        head_avg.avg, head_avg.row_end, head_avg.frame_end));
            end
        end
    end

    // small frames, zero registers, ignored edges, blocks larger than the frame
    task automatic test_directed_cases();
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(2));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
        write_register(REG_BLOCK_WIDTH, CFG_DATA_W'(2));
        write_register(REG_BLOCK_HEIGHT, CFG_DATA_W'(2));
        send_pixel(8'h00);
        send_pixel(8'hFF);
        // index past the register list must not restart the frame
        write_register(CFG_IDX_W'(255), '1);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        repeat (4) send_pixel(8'hFF);
        // zero acts as one everywhere
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(0));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(0));
        write_register(REG_BLOCK_WIDTH, CFG_DATA_W'(0));
        write_register(REG_BLOCK_HEIGHT, CFG_DATA_W'(0));
        send_pixel(8'h00);
        send_pixel(8'hFF);
        // right column past the last whole block is dropped
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
        write_register(REG_BLOCK_WIDTH, CFG_DATA_W'(2));
        write_register(REG_BLOCK_HEIGHT, CFG_DATA_W'(1));
        repeat (3) send_pixel(random_pixel());
        // block bigger than the frame: nothing comes out
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        write_register(REG_BLOCK_WIDTH, CFG_DATA_W'(4));
        write_register(REG_BLOCK_HEIGHT, CFG_DATA_W'(4));
        repeat (9) send_pixel(random_pixel());
    endtask

    // saturating size and factor values, on cut wide and tall frames
    task automatic test_size_extremes();
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(MAX_W, 2047)));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
        write_register(REG_BLOCK_WIDTH, CFG_DATA_W'($urandom_range(MAX_F, 15)));
        write_register(REG_BLOCK_HEIGHT, CFG_DATA_W'(1));
        repeat (WIDE_PIXELS) send_pixel(random_pixel());
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(1));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(MAX_W, 2047)));
        write_register(REG_BLOCK_WIDTH, CFG_DATA_W'(0));
        write_register(REG_BLOCK_HEIGHT, CFG_DATA_W'(MAX_F));
        repeat (TALL_PIXELS) send_pixel(random_pixel());
    endtask

    // random settings, mostly whole frames, some cut frames and drains
    task automatic test_random_frames();
        int start_count, phase, n_writes, len;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        start_count = pixel_count;
        phase = 0;
        while (pixel_count - start_count < RANDOM_PIXELS)
        begin
            // a long calm stretch early in the run
            sender_idle_en    = !(phase >= 3 && phase < 8);
            receiver_stall_en = sender_idle_en;
            n_writes = (phase == 0) ? 4 : $urandom_range(1, 4);
            for (int k = 0; k < n_writes; k++)
            begin
                if (phase == 0)
                    idx = CFG_IDX_W'(k);
                else if ($urandom_range(9) == 0)
                    idx = CFG_IDX_W'($urandom_range(REG_COUNT, 255));
                else
                    idx = CFG_IDX_W'($urandom_range(REG_BLOCK_HEIGHT));
                case (idx)
                    REG_FRAME_WIDTH:  data = CFG_DATA_W'($urandom_range(0, 16));
                    REG_FRAME_HEIGHT: data = CFG_DATA_W'($urandom_range(0, 8));
                    REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT:
                        data = {7'($urandom), ($urandom_range(3) == 0) ?
                                FACTOR_REG_W'($urandom_range(0, 15)) :
                                FACTOR_REG_W'($urandom_range(1, 4))};
                    default: data = CFG_DATA_W'($urandom);
                endcase
                write_register(idx, data);
            end
            case ($urandom_range(9))
                0:
                begin
                    // frame may be cut short; the next write to a listed register restarts it
                    repeat ($urandom_range(1, frame_pixels())) send_pixel(random_pixel());
                end
                1:
                begin
                    // sender holds off until every average is out
                    len = frame_pixels();
                    repeat (len / 2) send_pixel(random_pixel());
                    stop_pixels();
                    wait_for_averages();
                    repeat (len - len / 2) send_pixel(random_pixel());
                end
                default:
                begin
                    repeat ($urandom_range(1, 2) * frame_pixels()) send_pixel(random_pixel());
                end
            endcase
            phase++;
        end
        sender_idle_en    = 1'b1;
        receiver_stall_en = 1'b1;
    endtask

    // main sequence
    initial
    begin : main_seq
        int wait_cycles;
        rst_n            = 1'b0;
        pix_if.valid     = 1'b0;
        pix_if.pixel_in  = '0;
        avg_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        frame_width_reg  = FRAME_WIDTH_RST;
        frame_height_reg = FRAME_HEIGHT_RST;
        block_width_reg  = BLOCK_WIDTH_RST;
        block_height_reg = BLOCK_HEIGHT_RST;
        restart_position();
        mismatch_count    = 0;
        pixel_count       = 0;
        avg_count         = 0;
        reg_write_count   = 0;
        sender_idle_en    = 1'b1;
        receiver_stall_en = 1'b1;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_size_extremes();
        test_random_frames();

        // drain and let the block settle
        stop_pixels();
        wait_cycles = 0;
        while (pending_avgs.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (pending_avgs.size() != 0)
            report_mismatch($sformatf("%0d averages never arrived", pending_avgs.size()));

        $display("covered %0d pixels, %0d averages, %0d register writes", pixel_count,
                 avg_count, reg_write_count);
        $display("small frames up to 16x8, factors 1 to 8, saturated sizes on cut frames");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> box_average_downscaler.f
rtl/bxavg_pkg.sv
rtl/bxavg_if.sv
rtl/bxavg_cfg.sv
rtl/bxavg_ctrl.sv
rtl/bxavg_dp.sv
rtl/box_average_downscaler.sv
sim/box_average_downscaler_tb.sv
